// ----- rtl/ile_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ile_pkg;

    // store size and derived widths
    localparam int CAPACITY = 64;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int CNT_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STAT_W   = 2;

    typedef logic [SLOT_W-1:0] t_slot;

    // request opcodes
    localparam logic [OP_W-1:0] OP_READ      = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD_BACK  = 3'd2;
    localparam logic [OP_W-1:0] OP_INSERT    = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE    = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // read value for anything that is not a successful read
    localparam logic signed [DATA_W-1:0] NO_VALUE = -32'sd1;

    // list length when every slot is in use
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    typedef struct packed {
        logic        [OP_W-1:0]   opcode;
        logic        [POS_W-1:0]  position;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic        [STAT_W-1:0] status;
        logic        [CNT_W-1:0]  element_count;
    } t_rsp;

    // port control of a memory holding slot numbers
    typedef struct packed {
        logic  we;
        t_slot waddr;
        t_slot wdata;
        t_slot raddr;
    } t_link_ctl;

    // port control of the value memory
    typedef struct packed {
        logic                     we;
        t_slot                    waddr;
        logic signed [DATA_W-1:0] wdata;
        t_slot                    raddr;
    } t_val_ctl;

endpackage

`default_nettype wire

// ----- rtl/ile_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ile_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/ile_free_stack.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ile_free_stack (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ile_pkg::t_link_ctl i_ctl,
    output ile_pkg::t_slot          o_slot
);

    logic [ile_pkg::CAPACITY-1:0] r_valid;
    logic                         r_hit;
    ile_pkg::t_slot               r_idx;
    ile_pkg::t_slot               w_rdata;

    ile_ram #(
        .WIDTH (ile_pkg::SLOT_W),
        .DEPTH (ile_pkg::CAPACITY)
    ) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.we),
        .i_waddr (i_ctl.waddr),
        .i_wdata (i_ctl.wdata),
        .i_raddr (i_ctl.raddr),
        .o_rdata (w_rdata)
    );

    // written marks, cleared by reset so that entry i reads as slot i
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.we) begin
            r_valid[i_ctl.waddr] <= 1'b1;
        end
    end

    // follow the read address alongside the memory latency
    always_ff @(posedge i_clk) begin
        r_hit <= r_valid[i_ctl.raddr];
        r_idx <= i_ctl.raddr;
    end

    assign o_slot = r_hit ? w_rdata : r_idx;

endmodule

`default_nettype wire

// ----- rtl/ile_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ile_seq (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire ile_pkg::t_req                   i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output ile_pkg::t_rsp                        o_out_data,
    output ile_pkg::t_val_ctl                    o_vs_ctl,
    input  wire logic signed [ile_pkg::DATA_W-1:0] i_vs_rdata,
    output ile_pkg::t_link_ctl                   o_nl_ctl,
    input  wire ile_pkg::t_slot                  i_nl_rdata,
    output ile_pkg::t_link_ctl                   o_pl_ctl,
    input  wire ile_pkg::t_slot                  i_pl_rdata,
    output ile_pkg::t_link_ctl                   o_fr_ctl,
    input  wire ile_pkg::t_slot                  i_fr_slot
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_DECODE = 10'b00_0000_0010,
        S_FREE   = 10'b00_0000_0100,
        S_WALK   = 10'b00_0000_1000,
        S_AT     = 10'b00_0001_0000,
        S_RDVAL  = 10'b00_0010_0000,
        S_INS_P  = 10'b00_0100_0000,
        S_INS_2  = 10'b00_1000_0000,
        S_DEL    = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } t_state;

    t_state                                r_state, n_state;
    logic [ile_pkg::OP_W-1:0]              r_op, n_op;
    logic [ile_pkg::POS_W-1:0]             r_pos, n_pos;
    logic signed [ile_pkg::DATA_W-1:0]     r_val, n_val;
    logic [ile_pkg::CNT_W-1:0]             r_len, n_len;
    ile_pkg::t_slot                        r_first, n_first;
    ile_pkg::t_slot                        r_last, n_last;
    ile_pkg::t_slot                        r_cur, n_cur;
    ile_pkg::t_slot                        r_slot, n_slot;
    logic [ile_pkg::POS_W-1:0]             r_steps, n_steps;
    logic signed [ile_pkg::DATA_W-1:0]     r_rv, n_rv;
    logic [ile_pkg::STAT_W-1:0]            r_st, n_st;
    logic                                  r_out_valid, n_out_valid;
    ile_pkg::t_rsp                         r_out, n_out;

    logic [ile_pkg::POS_W-1:0]             w_eff_pos;
    logic [ile_pkg::CNT_W-1:0]             w_len_dec;

    // insert position after the add front and add back aliases
    always_comb begin
        case (r_op)
            ile_pkg::OP_ADD_FRONT: w_eff_pos = '0;
            ile_pkg::OP_ADD_BACK:  w_eff_pos = r_len;
            default:               w_eff_pos = r_pos;
        endcase
    end

    assign w_len_dec = r_len - ile_pkg::CNT_W'(1);

    // request sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_pos       = r_pos;
        n_val       = r_val;
        n_len       = r_len;
        n_first     = r_first;
        n_last      = r_last;
        n_cur       = r_cur;
        n_slot      = r_slot;
        n_steps     = r_steps;
        n_rv        = r_rv;
        n_st        = r_st;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_vs_ctl    = '0;
        o_nl_ctl    = '0;
        o_pl_ctl    = '0;
        o_fr_ctl    = '0;

        // result taken downstream
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_in_data.opcode;
                    n_pos   = i_in_data.position;
                    n_val   = i_in_data.value;
                    n_rv    = ile_pkg::NO_VALUE;
                    n_st    = ile_pkg::ST_DONE;
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                unique case (r_op) inside
                    ile_pkg::OP_READ, ile_pkg::OP_DELETE: begin
                        if (r_pos >= r_len) begin
                            n_st    = ile_pkg::ST_RANGE;
                            n_state = S_DONE;
                        end else if (r_pos == '0) begin
                            n_cur   = r_first;
                            n_state = S_AT;
                        end else begin
                            o_nl_ctl.raddr = r_first;
                            n_steps        = r_pos - ile_pkg::POS_W'(1);
                            n_state        = S_WALK;
                        end
                    end
                    ile_pkg::OP_ADD_FRONT, ile_pkg::OP_ADD_BACK, ile_pkg::OP_INSERT: begin
                        if (w_eff_pos > r_len) begin
                            n_st    = ile_pkg::ST_RANGE;
                            n_state = S_DONE;
                        end else if (r_len >= ile_pkg::FULL_COUNT) begin
                            n_st    = ile_pkg::ST_FULL;
                            n_state = S_DONE;
                        end else begin
                            o_fr_ctl.raddr = r_len[ile_pkg::SLOT_W-1:0];
                            n_pos          = w_eff_pos;
                            n_state        = S_FREE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            // free slot known: store the value and link it in at either end, else start the walk
            S_FREE: begin
                n_slot         = i_fr_slot;
                o_vs_ctl.we    = 1'b1;
                o_vs_ctl.waddr = i_fr_slot;
                o_vs_ctl.wdata = r_val;
                if (r_len == '0) begin
                    n_first = i_fr_slot;
                    n_last  = i_fr_slot;
                    n_len   = r_len + ile_pkg::CNT_W'(1);
                    n_state = S_DONE;
                end else if (r_pos == '0) begin
                    o_nl_ctl.we    = 1'b1;
                    o_nl_ctl.waddr = i_fr_slot;
                    o_nl_ctl.wdata = r_first;
                    o_pl_ctl.we    = 1'b1;
                    o_pl_ctl.waddr = r_first;
                    o_pl_ctl.wdata = i_fr_slot;
                    n_first        = i_fr_slot;
                    n_len          = r_len + ile_pkg::CNT_W'(1);
                    n_state        = S_DONE;
                end else if (r_pos == r_len) begin
                    o_pl_ctl.we    = 1'b1;
                    o_pl_ctl.waddr = i_fr_slot;
                    o_pl_ctl.wdata = r_last;
                    o_nl_ctl.we    = 1'b1;
                    o_nl_ctl.waddr = r_last;
                    o_nl_ctl.wdata = i_fr_slot;
                    n_last         = i_fr_slot;
                    n_len          = r_len + ile_pkg::CNT_W'(1);
                    n_state        = S_DONE;
                end else begin
                    o_nl_ctl.raddr = r_first;
                    n_steps        = r_pos - ile_pkg::POS_W'(1);
                    n_state        = S_WALK;
                end
            end

            // chase next links, one slot per cycle
            S_WALK: begin
                if (r_steps == '0) begin
                    n_cur   = i_nl_rdata;
                    n_state = S_AT;
                end else begin
                    o_nl_ctl.raddr = i_nl_rdata;
                    n_steps        = r_steps - ile_pkg::POS_W'(1);
                end
            end

            // slot at the position reached
            S_AT: begin
                if (r_op == ile_pkg::OP_READ) begin
                    o_vs_ctl.raddr = r_cur;
                    n_state        = S_RDVAL;
                end else if (r_op == ile_pkg::OP_DELETE) begin
                    o_nl_ctl.raddr = r_cur;
                    o_pl_ctl.raddr = r_cur;
                    n_state        = S_DEL;
                end else begin
                    o_pl_ctl.raddr = r_cur;
                    n_state        = S_INS_P;
                end
            end

            S_RDVAL: begin
                n_rv    = i_vs_rdata;
                n_state = S_DONE;
            end

            // link predecessor and new slot
            S_INS_P: begin
                o_nl_ctl.we    = 1'b1;
                o_nl_ctl.waddr = i_pl_rdata;
                o_nl_ctl.wdata = r_slot;
                o_pl_ctl.we    = 1'b1;
                o_pl_ctl.waddr = r_slot;
                o_pl_ctl.wdata = i_pl_rdata;
                n_state        = S_INS_2;
            end

            // link new slot and the slot it goes before
            S_INS_2: begin
                o_nl_ctl.we    = 1'b1;
                o_nl_ctl.waddr = r_slot;
                o_nl_ctl.wdata = r_cur;
                o_pl_ctl.we    = 1'b1;
                o_pl_ctl.waddr = r_cur;
                o_pl_ctl.wdata = r_slot;
                n_len          = r_len + ile_pkg::CNT_W'(1);
                n_state        = S_DONE;
            end

            // unlink the slot and push it back on the free stack
            S_DEL: begin
                if (r_len > ile_pkg::CNT_W'(1)) begin
                    if (r_pos == '0) begin
                        n_first = i_nl_rdata;
                    end else if (r_pos == w_len_dec) begin
                        n_last = i_pl_rdata;
                    end else begin
                        o_nl_ctl.we    = 1'b1;
                        o_nl_ctl.waddr = i_pl_rdata;
                        o_nl_ctl.wdata = i_nl_rdata;
                        o_pl_ctl.we    = 1'b1;
                        o_pl_ctl.waddr = i_nl_rdata;
                        o_pl_ctl.wdata = i_pl_rdata;
                    end
                end
                o_fr_ctl.we    = 1'b1;
                o_fr_ctl.waddr = w_len_dec[ile_pkg::SLOT_W-1:0];
                o_fr_ctl.wdata = r_cur;
                n_len          = w_len_dec;
                n_state        = S_DONE;
            end

            // hand the result to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.read_value    = r_rv;
                    n_out.status        = r_st;
                    n_out.element_count = r_len;
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_first     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_first     <= n_first;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_pos   <= n_pos;
        r_val   <= n_val;
        r_cur   <= n_cur;
        r_slot  <= n_slot;
        r_steps <= n_steps;
        r_rv    <= n_rv;
        r_st    <= n_st;
        r_out   <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- rtl/indexed_list_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of signed 32-bit values in a store of ile_pkg::CAPACITY slots, kept
// as a doubly linked list in three one-port-read memories (value, next link,
// previous link) plus a free-slot stack. One request is worked at a time and
// answers with exactly one result. Requests that need no position (add front,
// add back, out-of-range or full store, unknown opcode) follow no links. Read
// and delete follow next links from the front, one slot per cycle through the
// next-link memory. Insert in the middle also fetches a free slot and writes
// two link pairs. The result sits in an output register, so a new request may
// be accepted while the last result still waits to be taken. No clearing pass
// is needed after reset.
module indexed_list_engine (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire ile_pkg::t_req i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output ile_pkg::t_rsp      o_out_data
);

    ile_pkg::t_val_ctl                 w_vs_ctl;
    ile_pkg::t_link_ctl                w_nl_ctl;
    ile_pkg::t_link_ctl                w_pl_ctl;
    ile_pkg::t_link_ctl                w_fr_ctl;
    logic signed [ile_pkg::DATA_W-1:0] w_vs_rdata;
    ile_pkg::t_slot                    w_nl_rdata;
    ile_pkg::t_slot                    w_pl_rdata;
    ile_pkg::t_slot                    w_fr_slot;

    // request sequencer
    ile_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_vs_ctl    (w_vs_ctl),
        .i_vs_rdata  (w_vs_rdata),
        .o_nl_ctl    (w_nl_ctl),
        .i_nl_rdata  (w_nl_rdata),
        .o_pl_ctl    (w_pl_ctl),
        .i_pl_rdata  (w_pl_rdata),
        .o_fr_ctl    (w_fr_ctl),
        .i_fr_slot   (w_fr_slot)
    );

    // slot values
    ile_ram #(
        .WIDTH (ile_pkg::DATA_W),
        .DEPTH (ile_pkg::CAPACITY)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (w_vs_ctl.we),
        .i_waddr (w_vs_ctl.waddr),
        .i_wdata (w_vs_ctl.wdata),
        .i_raddr (w_vs_ctl.raddr),
        .o_rdata (w_vs_rdata)
    );

    // forward links
    ile_ram #(
        .WIDTH (ile_pkg::SLOT_W),
        .DEPTH (ile_pkg::CAPACITY)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (w_nl_ctl.we),
        .i_waddr (w_nl_ctl.waddr),
        .i_wdata (w_nl_ctl.wdata),
        .i_raddr (w_nl_ctl.raddr),
        .o_rdata (w_nl_rdata)
    );

    // backward links
    ile_ram #(
        .WIDTH (ile_pkg::SLOT_W),
        .DEPTH (ile_pkg::CAPACITY)
    ) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (w_pl_ctl.we),
        .i_waddr (w_pl_ctl.waddr),
        .i_wdata (w_pl_ctl.wdata),
        .i_raddr (w_pl_ctl.raddr),
        .o_rdata (w_pl_rdata)
    );

    // free slots
    ile_free_stack u_free (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_fr_ctl),
        .o_slot  (w_fr_slot)
    );

endmodule

`default_nettype wire
